### src/vmd_pkg.sv
// Package for the volume midpoint densifier: constants, types, helpers.
package vmd_pkg;
  localparam int Density = 4;
  localparam int MaxCoarseEdge = 9;
  localparam int Edge = (MaxCoarseEdge - 1) * Density + 1;
  localparam int Depth = Edge * Edge * Edge;
  localparam int AddrW = $clog2(Depth);
  localparam int CoordW = 6;
  localparam int ValW = 16;
  localparam int SumW = ValW + 4;

  localparam logic [1:0] ModeWrite = 2'd0;
  localparam logic [1:0] ModeDensify = 2'd1;
  localparam logic [1:0] ModeRead = 2'd2;

  localparam logic [1:0] RegLenX = 2'd0;
  localparam logic [1:0] RegLenY = 2'd1;
  localparam logic [1:0] RegLenZ = 2'd2;
  localparam logic [1:0] RegAbsent = 2'd3;

  typedef logic [CoordW-1:0] coord_t;

  function automatic logic [AddrW-1:0] vox_addr(coord_t x, coord_t y, coord_t z);
    logic [AddrW+CoordW-1:0] a;
    a = ({{AddrW{1'b0}}, x} * (AddrW+CoordW)'(Edge) + {{AddrW{1'b0}}, y})
        * (AddrW+CoordW)'(Edge) + {{AddrW{1'b0}}, z};
    return a[AddrW-1:0];
  endfunction

  function automatic logic [3:0] eff_len(logic [3:0] v);
    if (v < 4'd2) return 4'd2;
    if (v > 4'(MaxCoarseEdge)) return 4'(MaxCoarseEdge);
    return v;
  endfunction
endpackage

### src/vmd_ram.sv
// Generic single-port RAM with registered read.
module vmd_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

### src/vmd_div.sv
// Iterative signed division of a neighbor sum by a count (1..8), truncating toward zero.
module vmd_div import vmd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [SumW-1:0] sum,
  input  logic [3:0]             cnt,
  output logic                   done,
  output logic signed [ValW-1:0] quot
);
  logic [SumW-1:0] mag, q, rem;
  logic [4:0] bitno;
  logic neg, busy;
  logic [SumW:0] trial;
  always_comb trial = {rem[SumW-2:0], mag[SumW-1], 1'b0} >> 1;
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      neg <= sum[SumW-1];
      mag <= sum[SumW-1] ? SumW'(-sum) : SumW'(sum);
      rem <= '0;
      q <= '0;
      bitno <= 5'(SumW);
    end else if (busy) begin
      if (trial[SumW-1:0] >= {{(SumW-4){1'b0}}, cnt}) begin
        rem <= trial[SumW-1:0] - {{(SumW-4){1'b0}}, cnt};
        q <= {q[SumW-2:0], 1'b1};
      end else begin
        rem <= trial[SumW-1:0];
        q <= {q[SumW-2:0], 1'b0};
      end
      mag <= {mag[SumW-2:0], 1'b0};
      bitno <= bitno - 5'd1;
      if (bitno == 5'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
  logic [SumW-1:0] qf;
  always_comb begin
    qf = q;
    quot = neg ? ValW'(-qf) : ValW'(qf);
  end
endmodule

### src/volume_midpoint_densifier.sv
// Top level of the volume midpoint densifier.
//  channel  | dir | signals
//  s_axis   | in  | tdata: mode[1:0] pos_x[7:2] pos_y[13:8] pos_z[19:14] sample_in[35:20]
//  m_axis   | out | tdata: voxel_out[15:0] min_seen[31:16] max_seen[47:32] status[48]
//  cfg      | in  | cfg_we, cfg_index, cfg_data
// A write or no-op goes from S_IDLE straight to S_OUT; a read passes through S_RD first
// (one RAM access with registered read).
// Densify visits each voxel of a pass's class in turn; a filled voxel takes up to
// 8 RAM reads plus a 20-step divide.
// The volume RAM has no clear after reset; unwritten voxels read undefined.
// A result waits in the output register while the input is held off.
module volume_midpoint_densifier import vmd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // mode, pos_x, pos_y, pos_z, sample_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // voxel_out, min_seen, max_seen, status
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_LVL, S_VIS, S_NB, S_NBW, S_DIV, S_WR, S_NEXT, S_OUT
  } state_t;
  state_t state;

  logic [3:0] len_x, len_y, len_z;
  logic signed [ValW-1:0] absent, low_mark, high_mark, voxel;
  logic [9:0] sample_count;
  logic status;

  logic ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [ValW-1:0] ram_wdata, ram_rdata;
  vmd_ram #(.Width(ValW), .Depth(Depth)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  logic [1:0] mode;
  coord_t px, py, pz;
  logic signed [ValW-1:0] samp;
  assign mode = s_axis_tdata[1:0];
  assign px = s_axis_tdata[7:2];
  assign py = s_axis_tdata[13:8];
  assign pz = s_axis_tdata[19:14];
  assign samp = s_axis_tdata[35:20];

  coord_t dx, dy, dz;
  always_comb begin
    dx = CoordW'((eff_len(len_x) - 4'd1) * Density + 1);
    dy = CoordW'((eff_len(len_y) - 4'd1) * Density + 1);
    dz = CoordW'((eff_len(len_z) - 4'd1) * Density + 1);
  end

  // Densify walk state.
  logic [3:0] r;
  coord_t h, cx, cy, cz, rx, ry, rz;
  logic [2:0] pass, nb;
  logic signed [SumW-1:0] sum;
  logic [3:0] cnt;
  logic div_start, div_done;
  logic signed [ValW-1:0] quot;
  vmd_div u_div (.clk(clk), .rst(rst), .start(div_start), .sum(sum), .cnt(cnt),
                 .done(div_done), .quot(quot));

  // Pass classes: bit2 x, bit1 y, bit0 z.
  logic [2:0] cls;
  always_comb begin
    case (pass)
      3'd0: cls = 3'b111;
      3'd1: cls = 3'b110;
      3'd2: cls = 3'b101;
      3'd3: cls = 3'b011;
      3'd4: cls = 3'b010;
      3'd5: cls = 3'b001;
      default: cls = 3'b100;
    endcase
  end

  // Neighbor offset for index nb of current pass (-1, 0, +1 per axis) and enable.
  logic signed [1:0] ox, oy, oz;
  logic nb_en;
  logic bx, by, bz;
  always_comb begin
    bx = (cx == '0) || (cx == dx - 6'd1);
    by = (cy == '0) || (cy == dy - 6'd1);
    bz = (cz == '0) || (cz == dz - 6'd1);
    ox = '0; oy = '0; oz = '0; nb_en = 1'b1;
    case (pass)
      3'd0: begin
        ox = nb[2] ? 2'sd1 : -2'sd1; oy = nb[1] ? 2'sd1 : -2'sd1;
        oz = nb[0] ? 2'sd1 : -2'sd1;
      end
      3'd1, 3'd2, 3'd3: begin
        if (nb[2:1] == 2'b11) begin
          // Normal-axis pair, dropped on a border plane.
          nb_en = !((pass == 3'd1 && bz) || (pass == 3'd2 && by) || (pass == 3'd3 && bx));
          if (pass == 3'd1) oz = nb[0] ? 2'sd1 : -2'sd1;
          else if (pass == 3'd2) oy = nb[0] ? 2'sd1 : -2'sd1;
          else ox = nb[0] ? 2'sd1 : -2'sd1;
        end else begin
          if (pass == 3'd1) begin
            ox = nb[1] ? 2'sd1 : -2'sd1; oy = nb[0] ? 2'sd1 : -2'sd1;
          end else if (pass == 3'd2) begin
            ox = nb[1] ? 2'sd1 : -2'sd1; oz = nb[0] ? 2'sd1 : -2'sd1;
          end else begin
            oy = nb[1] ? 2'sd1 : -2'sd1; oz = nb[0] ? 2'sd1 : -2'sd1;
          end
          nb_en = !nb[2];
        end
      end
      default: begin
        // Edge midpoints: 2 along own axis, 4 across when interior.
        nb_en = (nb < 3'd6);
        if (nb[2:1] == 2'b00) begin
          if (pass == 3'd4) oy = nb[0] ? 2'sd1 : -2'sd1;
          else if (pass == 3'd5) oz = nb[0] ? 2'sd1 : -2'sd1;
          else ox = nb[0] ? 2'sd1 : -2'sd1;
        end else begin
          if (pass == 3'd4) nb_en = nb_en && !bx && !bz;
          else if (pass == 3'd5) nb_en = nb_en && !bx && !by;
          else nb_en = nb_en && !by && !bz;
          if ((nb[2:1] == 2'b01) && (pass != 3'd6)) begin
            ox = nb[0] ? 2'sd1 : -2'sd1;
          end else if (pass == 3'd5 || (pass == 3'd6 && nb[2:1] == 2'b01)) begin
            oy = nb[0] ? 2'sd1 : -2'sd1;
          end else begin
            oz = nb[0] ? 2'sd1 : -2'sd1;
          end
        end
      end
    endcase
  end

  logic [CoordW:0] nx, ny, nz;
  logic nb_in;
  always_comb begin
    nx = {1'b0, cx} + (ox == 2'sd1 ? {1'b0, h} : ox == -2'sd1 ? -{1'b0, h} : '0);
    ny = {1'b0, cy} + (oy == 2'sd1 ? {1'b0, h} : oy == -2'sd1 ? -{1'b0, h} : '0);
    nz = {1'b0, cz} + (oz == 2'sd1 ? {1'b0, h} : oz == -2'sd1 ? -{1'b0, h} : '0);
    nb_in = !nx[CoordW] && !ny[CoordW] && !nz[CoordW] &&
            nx[CoordW-1:0] < dx && ny[CoordW-1:0] < dy && nz[CoordW-1:0] < dz;
  end

  // Walk the class residue: start at rx, step by r.
  logic [CoordW:0] sx, sy, sz;
  always_comb begin
    sx = {1'b0, cx} + {3'b0, r};
    sy = {1'b0, cy} + {3'b0, r};
    sz = {1'b0, cz} + {3'b0, r};
    rx = cls[2] ? h : '0;
    ry = cls[1] ? h : '0;
    rz = cls[0] ? h : '0;
  end

  // High in the first cycle of S_DIV, once sum and count are final.
  logic div_kick;
  assign div_start = div_kick && (cnt != 4'd0);

  always_comb begin
    ram_we = 1'b0;
    ram_addr = vox_addr(nx[CoordW-1:0], ny[CoordW-1:0], nz[CoordW-1:0]);
    ram_wdata = quot;
    if (state == S_IDLE) begin
      if (mode == ModeWrite) begin
        ram_addr = vox_addr(CoordW'(px * Density), CoordW'(py * Density),
                            CoordW'(pz * Density));
        ram_wdata = samp;
      end else ram_addr = vox_addr(px, py, pz);
      ram_we = s_axis_tvalid && s_axis_tready && mode == ModeWrite &&
               px < 6'(eff_len(len_x)) && py < 6'(eff_len(len_y)) &&
               pz < 6'(eff_len(len_z));
    end else if (state == S_WR) begin
      ram_addr = vox_addr(cx, cy, cz);
      ram_we = 1'b1;
      ram_wdata = (cnt == 4'd0) ? '0 : quot;
    end
  end

  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      low_mark <= '0;
      high_mark <= '0;
      sample_count <= '0;
      div_kick <= 1'b0;
      len_x <= 4'd9; len_y <= 4'd9; len_z <= 4'd9;
      absent <= 16'sd257;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          RegLenX: len_x <= cfg_data[3:0];
          RegLenY: len_y <= cfg_data[3:0];
          RegLenZ: len_z <= cfg_data[3:0];
          RegAbsent: absent <= cfg_data;
          default: ;
        endcase
      end
      if (state == S_OUT) m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          voxel <= '0;
          if (mode == ModeWrite) begin
            state <= S_OUT;
            if (ram_we) begin
              status <= 1'b0;
              if (sample_count == 10'd0) begin
                low_mark <= samp; high_mark <= samp;
              end else if (samp < low_mark) low_mark <= samp;
              else if (samp > high_mark) high_mark <= samp;
              if (sample_count != 10'd1023) sample_count <= sample_count + 10'd1;
            end else status <= 1'b1;
          end else if (mode == ModeRead) begin
            if (px < dx && py < dy && pz < dz) begin
              status <= 1'b0;
              state <= S_RD;
            end else begin
              status <= 1'b1;
              state <= S_OUT;
            end
          end else if (mode == ModeDensify) begin
            status <= 1'b0;
            r <= 4'(Density);
            h <= CoordW'(Density / 2);
            pass <= '0;
            state <= S_LVL;
          end else begin
            status <= 1'b0;
            state <= S_OUT;
          end
        end
        S_RD: begin
          voxel <= ram_rdata;
          state <= S_OUT;
        end
        S_LVL: begin
          cx <= rx; cy <= ry; cz <= rz;
          state <= (rx < dx && ry < dy && rz < dz) ? S_VIS : S_NEXT;
          nb <= '0; sum <= '0; cnt <= '0;
        end
        S_VIS: begin
          nb <= '0; sum <= '0; cnt <= '0;
          state <= S_NB;
        end
        S_NB: begin
          if (nb_en && nb_in) state <= S_NBW;
          else if (nb == 3'd7) begin
            state <= S_DIV;
            div_kick <= 1'b1;
          end else nb <= nb + 3'd1;
        end
        S_NBW: begin
          if (ram_rdata != absent) begin
            sum <= sum + SumW'($signed(ram_rdata));
            cnt <= cnt + 4'd1;
          end
          if (nb == 3'd7) begin
            state <= S_DIV;
            div_kick <= 1'b1;
          end else begin
            nb <= nb + 3'd1;
            state <= S_NB;
          end
        end
        S_DIV: begin
          div_kick <= 1'b0;
          if (div_done || cnt == 4'd0) state <= S_WR;
        end
        S_WR: begin
          if (sz < {1'b0, dz}) begin
            cz <= sz[CoordW-1:0]; state <= S_VIS;
          end else if (sy < {1'b0, dy}) begin
            cz <= rz; cy <= sy[CoordW-1:0]; state <= S_VIS;
          end else if (sx < {1'b0, dx}) begin
            cz <= rz; cy <= ry; cx <= sx[CoordW-1:0]; state <= S_VIS;
          end else state <= S_NEXT;
        end
        S_NEXT: begin
          if (pass != 3'd6) begin
            pass <= pass + 3'd1; state <= S_LVL;
          end else if (r >= 4'd4) begin
            pass <= '0; r <= r >> 1; h <= CoordW'(r >> 2); state <= S_LVL;
          end else state <= S_OUT;
        end
        S_OUT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {7'd0, status, high_mark, low_mark, voxel};

  // A transfer in is never taken while a result waits.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input accepted with result pending");
  a_marks: assert property (@(posedge clk) disable iff (rst)
    (sample_count != 0) |-> (low_mark <= high_mark))
    else $error("low mark above high mark");
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_IDLE || state == S_WR))
    else $error("volume write outside write or fill step");
endmodule

### test/volume_midpoint_densifier_test.sv
// Testbench for the volume midpoint densifier: stream driver, result checker, volume predictor.
`timescale 1ns / 1ps

module volume_midpoint_densifier_test;
  import vmd_pkg::*;

  localparam logic [1:0] ModeIdle = 2'd3;
  localparam int CycleLimit = 20_000_000;

  typedef struct packed {
    logic [1:0]         mode;
    coord_t             x;
    coord_t             y;
    coord_t             z;
    logic signed [15:0] sample;
  } voxel_op_t;

  typedef struct packed {
    logic signed [15:0] voxel;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    logic               status;
  } voxel_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // mode, pos_x, pos_y, pos_z, sample_in
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;        // voxel_out, min_seen, max_seen, status
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = RegLenX;
  logic [15:0] cfg_data = '0;

  volume_midpoint_densifier DUT (.*);

  always #5 clk = ~clk;

  // predictor state
  logic signed [15:0] vol [Depth];
  logic signed [15:0] low_mark, high_mark;
  int                 samples_taken;
  logic [3:0]         len_reg [3];
  logic signed [15:0] absent;
  longint             acc_sum;
  int                 acc_n;

  // planner state, updated as items are queued
  bit                 planned [Depth];
  int                 plan_len [3];
  bit                 smoothed;

  voxel_op_t    pending [$];
  voxel_reply_t replies_due [$];
  voxel_op_t    cur_op;
  int           cyc = 0;
  int           errors = 0;
  int           replies_seen = 0;
  int           hold_cnt = 0;
  bit           hold_done = 0;
  int           queued = 0;

  function automatic int clamp_len(logic [3:0] v);
    if (v < 2) return 2;
    if (v > MaxCoarseEdge) return MaxCoarseEdge;
    return int'(v);
  endfunction

  function automatic int idx(int x, int y, int z);
    return (x * Edge + y) * Edge + z;
  endfunction

  function automatic int dense_len(int a);
    return (clamp_len(len_reg[a]) - 1) * Density + 1;
  endfunction

  task automatic gather(int x, int y, int z);
    if (x < 0 || y < 0 || z < 0 || x >= dense_len(0) || y >= dense_len(1) || z >= dense_len(2))
      return;
    if (vol[idx(x, y, z)] == absent) return;
    acc_sum += vol[idx(x, y, z)];
    acc_n++;
  endtask

  task automatic fill_voxel(int p, int x, int y, int z, int h);
    bit bx, by, bz;
    bx = (x == 0 || x == dense_len(0) - 1);
    by = (y == 0 || y == dense_len(1) - 1);
    bz = (z == 0 || z == dense_len(2) - 1);
    acc_sum = 0;
    acc_n = 0;
    case (p)
      0: begin
        for (int i = 0; i < 8; i++)
          gather(x + (i[0] ? h : -h), y + (i[1] ? h : -h), z + (i[2] ? h : -h));
      end
      1: begin
        if (!bz) begin gather(x, y, z - h); gather(x, y, z + h); end
        gather(x + h, y + h, z); gather(x + h, y - h, z);
        gather(x - h, y + h, z); gather(x - h, y - h, z);
      end
      2: begin
        if (!by) begin gather(x, y - h, z); gather(x, y + h, z); end
        gather(x + h, y, z + h); gather(x + h, y, z - h);
        gather(x - h, y, z + h); gather(x - h, y, z - h);
      end
      3: begin
        if (!bx) begin gather(x - h, y, z); gather(x + h, y, z); end
        gather(x, y + h, z + h); gather(x, y + h, z - h);
        gather(x, y - h, z + h); gather(x, y - h, z - h);
      end
      4: begin
        gather(x, y - h, z); gather(x, y + h, z);
        if (!bx && !bz) begin
          gather(x - h, y, z); gather(x + h, y, z); gather(x, y, z - h); gather(x, y, z + h);
        end
      end
      5: begin
        gather(x, y, z - h); gather(x, y, z + h);
        if (!bx && !by) begin
          gather(x - h, y, z); gather(x + h, y, z); gather(x, y - h, z); gather(x, y + h, z);
        end
      end
      default: begin
        gather(x - h, y, z); gather(x + h, y, z);
        if (!by && !bz) begin
          gather(x, y - h, z); gather(x, y + h, z); gather(x, y, z - h); gather(x, y, z + h);
        end
      end
    endcase
    vol[idx(x, y, z)] = acc_n ? 16'(acc_sum / acc_n) : 16'sd0;
  endtask

  // pass classes: 1 means the coordinate sits at h modulo r
  task automatic densify_volume();
    bit [2:0] cls [7];
    int h, rx, ry, rz;
    cls = '{3'b111, 3'b110, 3'b101, 3'b011, 3'b010, 3'b001, 3'b100};
    for (int r = Density; r >= 2; r = r / 2) begin
      h = r / 2;
      for (int p = 0; p < 7; p++) begin
        rx = cls[p][2] ? h : 0;
        ry = cls[p][1] ? h : 0;
        rz = cls[p][0] ? h : 0;
        for (int x = 0; x < dense_len(0); x += h)
          if (x % r == rx)
            for (int y = 0; y < dense_len(1); y += h)
              if (y % r == ry)
                for (int z = 0; z < dense_len(2); z += h)
                  if (z % r == rz) fill_voxel(p, x, y, z, h);
      end
    end
  endtask

  task automatic predict_reply(voxel_op_t op);
    voxel_reply_t rep;
    rep = '0;
    case (op.mode)
      ModeWrite: begin
        if (op.x >= clamp_len(len_reg[0]) || op.y >= clamp_len(len_reg[1]) ||
            op.z >= clamp_len(len_reg[2])) begin
          rep.status = 1'b1;
        end else begin
          if (samples_taken == 0) begin
            low_mark = op.sample;
            high_mark = op.sample;
          end else if (op.sample < low_mark) begin
            low_mark = op.sample;
          end else if (op.sample > high_mark) begin
            high_mark = op.sample;
          end
          if (samples_taken < 1023) samples_taken++;
          vol[idx(op.x * Density, op.y * Density, op.z * Density)] = op.sample;
        end
      end
      ModeDensify: densify_volume();
      ModeRead: begin
        if (op.x >= dense_len(0) || op.y >= dense_len(1) || op.z >= dense_len(2))
          rep.status = 1'b1;
        else
          rep.voxel = vol[idx(op.x, op.y, op.z)];
      end
      default: ;
    endcase
    rep.lo = low_mark;
    rep.hi = high_mark;
    replies_due.push_back(rep);
  endtask

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic bit jitter_on();
    return (cyc % 30000) >= 6000;
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_reply(cur_op);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending.size() != 0 && !(jitter_on() && $urandom_range(99) < 28)) begin
          cur_op = pending.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {4'b0, cur_op.sample, cur_op.z, cur_op.y, cur_op.x, cur_op.mode};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off once the stream is under way
  always @(posedge clk) begin
    if (!hold_done && replies_seen == 40) begin
      hold_cnt <= 600;
      hold_done <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= (hold_cnt == 0) && !(jitter_on() && $urandom_range(99) < 28);
  end

  // checker
  always @(posedge clk) begin
    voxel_reply_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32], m_axis_tdata[48]};
      replies_seen <= replies_seen + 1;
      if (replies_due.size() == 0) begin
        $error("unexpected transfer on result stream");
        errors++;
      end else begin
        want = replies_due.pop_front();
        if (got.voxel !== want.voxel) begin
          $error("voxel_out expected %0d got %0d", want.voxel, got.voxel); errors++;
        end
        if (got.lo !== want.lo) begin
          $error("min_seen expected %0d got %0d", want.lo, got.lo); errors++;
        end
        if (got.hi !== want.hi) begin
          $error("max_seen expected %0d got %0d", want.hi, got.hi); errors++;
        end
        if (got.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, got.status); errors++;
        end
      end
    end
  end

  // ---- stimulus planning ----
  task automatic queue_op(logic [1:0] mode, int x, int y, int z, logic signed [15:0] s);
    voxel_op_t op;
    op = '{mode, coord_t'(x), coord_t'(y), coord_t'(z), s};
    if (mode == ModeWrite && x < plan_len[0] && y < plan_len[1] && z < plan_len[2])
      planned[idx(x * Density, y * Density, z * Density)] = 1'b1;
    if (mode == ModeDensify) begin
      for (int i = 0; i < (plan_len[0] - 1) * Density + 1; i++)
        for (int j = 0; j < (plan_len[1] - 1) * Density + 1; j++)
          for (int k = 0; k < (plan_len[2] - 1) * Density + 1; k++)
            planned[idx(i, j, k)] = 1'b1;
      smoothed = 1'b1;
    end
    pending.push_back(op);
    queued++;
  endtask

  task automatic wait_idle();
    while (pending.size() != 0 || s_axis_tvalid || replies_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (index == RegAbsent) absent = value;
    else len_reg[index] = value[3:0];
    if (index != RegAbsent) plan_len[index] = clamp_len(value[3:0]);
    smoothed = 1'b0;
  endtask

  function automatic logic signed [15:0] pick_sample();
    int c;
    c = $urandom_range(99);
    if (c < 12) return absent;
    if (c < 20) return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    if (c < 55) return 16'($signed($urandom_range(600)) - 300);
    return 16'($urandom);
  endfunction

  task automatic queue_read();
    int x, y, z;
    if (smoothed) begin
      x = $urandom_range((plan_len[0] - 1) * Density);
      y = $urandom_range((plan_len[1] - 1) * Density);
      z = $urandom_range((plan_len[2] - 1) * Density);
    end else begin
      x = $urandom_range(plan_len[0] - 1) * Density;
      y = $urandom_range(plan_len[1] - 1) * Density;
      z = $urandom_range(plan_len[2] - 1) * Density;
    end
    if (planned[idx(x, y, z)]) queue_op(ModeRead, x, y, z, 16'($urandom));
  endtask

  // coordinates with at least one axis beyond the given bounds
  task automatic queue_outside(logic [1:0] mode, int bx, int by, int bz);
    int c[3], b[3], a;
    b = '{bx, by, bz};
    for (int i = 0; i < 3; i++) c[i] = $urandom_range(63);
    a = $urandom_range(2);
    if (c[a] < b[a]) c[a] = $urandom_range(63, b[a]);
    queue_op(mode, c[0], c[1], c[2], 16'($urandom));
  endtask

  task automatic queue_mixed();
    int c;
    int dx, dy, dz;
    dx = (plan_len[0] - 1) * Density + 1;
    dy = (plan_len[1] - 1) * Density + 1;
    dz = (plan_len[2] - 1) * Density + 1;
    c = $urandom_range(99);
    if (c < 55) queue_read();
    else if (c < 70)
      queue_op(ModeWrite, $urandom_range(plan_len[0] - 1), $urandom_range(plan_len[1] - 1),
               $urandom_range(plan_len[2] - 1), pick_sample());
    else if (c < 78) queue_outside(ModeWrite, plan_len[0], plan_len[1], plan_len[2]);
    else if (c < 88) queue_outside(ModeRead, dx, dy, dz);
    else queue_op(ModeIdle, $urandom_range(63), $urandom_range(63), $urandom_range(63),
                  16'($urandom));
  endtask

  task automatic run_phase(logic [3:0] lx, logic [3:0] ly, logic [3:0] lz,
                           logic [15:0] marker);
    int n;
    wait_idle();
    write_reg(RegLenX, lx);
    write_reg(RegLenY, ly);
    write_reg(RegLenZ, lz);
    write_reg(RegAbsent, marker);
    for (int i = 0; i < plan_len[0]; i++)
      for (int j = 0; j < plan_len[1]; j++)
        for (int k = 0; k < plan_len[2]; k++)
          queue_op(ModeWrite, i, j, k, pick_sample());
    for (int i = 0; i < 8; i++) queue_mixed();
    // keep the refinement walk short: only small volumes get densified
    if (((plan_len[0] - 1) * Density + 1) * ((plan_len[1] - 1) * Density + 1) *
        ((plan_len[2] - 1) * Density + 1) <= 2500) begin
      queue_op(ModeDensify, $urandom_range(63), $urandom_range(63), $urandom_range(63),
               16'($urandom));
      n = 30 + $urandom_range(40);
      for (int i = 0; i < n; i++) queue_mixed();
      if ($urandom_range(3) == 0) begin
        queue_op(ModeDensify, 0, 0, 0, 16'sd0);
        for (int i = 0; i < 20; i++) queue_mixed();
      end
    end else begin
      for (int i = 0; i < 30; i++) queue_mixed();
    end
  endtask

  initial begin
    logic [3:0] l[3];
    for (int i = 0; i < Depth; i++) begin
      vol[i] = '0;
      planned[i] = 1'b0;
    end
    low_mark = '0;
    high_mark = '0;
    samples_taken = 0;
    len_reg = '{4'd9, 4'd9, 4'd9};
    plan_len = '{9, 9, 9};
    absent = 16'sd257;
    smoothed = 1'b0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings, field extremes, borders, outside coordinates
    queue_op(ModeRead, 33, 0, 0, 16'sd0);
    queue_op(ModeWrite, 0, 0, 0, 16'sh8000);
    queue_op(ModeWrite, 8, 8, 8, 16'sh7fff);
    queue_op(ModeWrite, 4, 2, 7, 16'sd257);
    queue_op(ModeWrite, 9, 0, 0, 16'sd5);
    queue_op(ModeWrite, 0, 63, 0, 16'sd5);
    queue_op(ModeWrite, 0, 0, 42, 16'sd5);
    queue_op(ModeRead, 32, 32, 32, 16'sd0);
    queue_op(ModeRead, 0, 0, 0, 16'sd0);
    queue_op(ModeRead, 16, 8, 28, 16'sd0);
    queue_op(ModeRead, 0, 33, 0, 16'sd0);
    queue_op(ModeRead, 0, 0, 63, 16'sd0);
    queue_op(ModeIdle, 63, 63, 63, 16'shffff);
    queue_op(ModeIdle, 0, 0, 0, 16'sd0);
    queue_op(ModeWrite, 1, 1, 1, 16'sd100);
    queue_op(ModeWrite, 2, 2, 2, 16'sh8001);
    queue_op(ModeRead, 4, 4, 4, 16'sd0);

    // setting extremes, then random small volumes
    run_phase(4'd15, 4'd2, 4'd2, 16'sh8000);
    run_phase(4'd1, 4'd15, 4'd0, 16'sh7fff);
    run_phase(4'd0, 4'd1, 4'd15, 16'sd0);
    run_phase(4'd2, 4'd2, 4'd2, 16'hffff);
    while (queued < 950) begin
      for (int a = 0; a < 3; a++)
        l[a] = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(4));
      if (clamp_len(l[0]) * clamp_len(l[1]) * clamp_len(l[2]) > 64) l[0] = 4'd2;
      if (clamp_len(l[0]) * clamp_len(l[1]) * clamp_len(l[2]) > 64) l[1] = 4'd2;
      run_phase(l[0], l[1], l[2], $urandom_range(3) == 0 ? 16'($urandom) : 16'(absent));
    end

    wait_idle();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
